@@ src/swmf_pkg.sv @@
// shared constants and types of the sliding window median filter
package swmf_pkg;

  localparam int WINDOW_MAX_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int WLEN_W = 5;
  localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd5;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // register index taken from paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  typedef struct packed {
    logic shift;
    logic count;
  } cell_ctrl_t;

endpackage

@@ src/swmf_cell.sv @@
// one cell of the window chain: holds a sample, a probe copy and its rank
module swmf_cell #(
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W       = 5,
  parameter int INDEX       = 0
) (
  input  logic                   clk_i,
  input  swmf_pkg::cell_ctrl_t   ctrl_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS-1:0] probe_i,
  input  logic [SAMPLE_BITS-1:0] bcast_i,
  input  logic [CNT_W-1:0]       step_i,
  output logic [SAMPLE_BITS-1:0] value_o,
  output logic [SAMPLE_BITS-1:0] probe_o,
  output logic [CNT_W-1:0]       rank_o
);

  logic [SAMPLE_BITS-1:0] value_q, value_d;
  logic [SAMPLE_BITS-1:0] probe_q, probe_d;
  logic [CNT_W-1:0]       rank_q, rank_d;
  logic                   beats;

  // ties ordered by position so ranks stay a permutation
  assign beats = ($signed(bcast_i) < $signed(value_q)) ||
                 ((bcast_i == value_q) && (step_i < CNT_W'(INDEX)));

  always_comb begin
    value_d = value_q;
    probe_d = probe_q;
    rank_d  = rank_q;
    if (ctrl_i.shift) begin
      value_d = sample_i;
      probe_d = sample_i;
      rank_d  = '0;
    end else if (ctrl_i.count) begin
      probe_d = probe_i;
      if (beats) begin
        rank_d = rank_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    probe_q <= probe_d;
    rank_q  <= rank_d;
  end

  assign value_o = value_q;
  assign probe_o = probe_q;
  assign rank_o  = rank_q;

endmodule

@@ src/sliding_window_median_filter.sv @@
// top level of the sliding window median filter
//
//   channel  | direction | handshake                  | payload
//   s_axis   | in        | s_axis_tvalid/tready       | tdata: sample, tlast: vector_end
//   m_axis   | out       | m_axis_tvalid/tready       | tdata: median, tlast: from_vector_end
//   apb      | in        | psel, penable, pready      | reg 0 at 0x0: window_length
//
// an item that gives no result is only shifted into the cell chain; one that gives
// a result is shifted into the cell chain, then takes rank steps while the probe
// chain walks past every cell of the effective window, then a pick step takes the median
// reset is asynchronous: window length 5, fill count 0, window cells not cleared
// the output register lets the next item in while a result waits; the pick
// step holds until the output register is free
module sliding_window_median_filter #(
  parameter int WINDOW_MAX  = swmf_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // sample
  input  logic                                s_axis_tlast,   // vector_end
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,   // median
  output logic                                m_axis_tlast,   // from_vector_end
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swmf_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [swmf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [swmf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_PICK
  } state_e;

  state_e                         state_q, state_d;
  logic [CNT_W-1:0]               step_q, step_d;
  logic [CNT_W-1:0]               fill_q, fill_d;
  logic                           last_q, last_d;
  logic [swmf_pkg::WLEN_W-1:0]    wlen_q, wlen_d;
  logic                           out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]         out_median_q, out_median_d;
  logic                           out_last_q, out_last_d;

  logic [CNT_W-1:0]               len_eff;
  logic [CNT_W-1:0]               half;
  logic [CNT_W-1:0]               fill_inc;
  logic                           in_acc;
  logic                           cfg_wr;
  logic [SAMPLE_BITS-1:0]         pick;
  swmf_pkg::cell_ctrl_t           ctrl;

  logic [SAMPLE_BITS-1:0]         value [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]         probe [WINDOW_MAX];
  logic [CNT_W-1:0]               rank  [WINDOW_MAX];

  // effective window length
  always_comb begin
    if (wlen_q == '0) begin
      len_eff = CNT_W'(1);
    end else if (int'(wlen_q) > WINDOW_MAX) begin
      len_eff = CNT_W'(WINDOW_MAX);
    end else begin
      len_eff = CNT_W'(wlen_q);
    end
  end

  assign half     = len_eff >> 1;
  assign fill_inc = (fill_q == CNT_W'(WINDOW_MAX)) ? fill_q : fill_q + CNT_W'(1);
  assign in_acc   = s_axis_tvalid && (state_q == ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite;

  assign ctrl.shift = in_acc;
  assign ctrl.count = (state_q == ST_COUNT);

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] sample_in;
    logic [SAMPLE_BITS-1:0] probe_in;
    if (i == 0) begin : g_head
      assign sample_in = s_axis_tdata[SAMPLE_BITS-1:0];
    end else begin : g_body
      assign sample_in = value[i-1];
    end
    if (i == WINDOW_MAX - 1) begin : g_tail
      assign probe_in = probe[i];
    end else begin : g_link
      assign probe_in = probe[i+1];
    end
    swmf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .sample_i(sample_in),
      .probe_i (probe_in),
      .bcast_i (probe[0]),
      .step_i  (step_q),
      .value_o (value[i]),
      .probe_o (probe[i]),
      .rank_o  (rank[i])
    );
  end

  // the cell whose rank is the middle one
  always_comb begin
    pick = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if ((CNT_W'(i) < len_eff) && (rank[i] == half)) begin
        pick = pick | value[i];
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    fill_d       = fill_q;
    last_d       = last_q;
    wlen_d       = wlen_q;
    out_valid_d  = out_valid_q;
    out_median_d = out_median_q;
    out_last_d   = out_last_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_wr && (paddr[2] == swmf_pkg::REG_WINDOW_LENGTH)) begin
      wlen_d = pwdata[swmf_pkg::WLEN_W-1:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          last_d = s_axis_tlast;
          fill_d = s_axis_tlast ? '0 : fill_inc;
          if (fill_inc >= len_eff) begin
            state_d = ST_COUNT;
            step_d  = '0;
          end
        end
      end
      ST_COUNT: begin
        step_d = step_q + CNT_W'(1);
        if (step_q == len_eff - CNT_W'(1)) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_median_d = pick;
          out_last_d   = last_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      fill_q       <= '0;
      last_q       <= 1'b0;
      wlen_q       <= swmf_pkg::WLEN_RESET;
      out_valid_q  <= 1'b0;
      out_median_q <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      fill_q       <= fill_d;
      last_q       <= last_d;
      wlen_q       <= wlen_d;
      out_valid_q  <= out_valid_d;
      out_median_q <= out_median_d;
      out_last_q   <= out_last_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_W'(out_median_q);
  assign m_axis_tlast  = out_last_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == swmf_pkg::REG_WINDOW_LENGTH) ?
                  swmf_pkg::APB_DATA_W'(wlen_q) : '0;

endmodule

@@ src/swmf_checker.sv @@
// port checker of the sliding window median filter and its bind
module swmf_checker #(
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata,
  input logic                               m_axis_tlast,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [swmf_pkg::APB_ADDR_W-1:0]    paddr,
  input logic [swmf_pkg::APB_DATA_W-1:0]    pwdata,
  input logic [swmf_pkg::APB_DATA_W-1:0]    prdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a new result only comes out of a ranking pass
  a_out_after_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without ranking pass");

  // window length register reads back only its own bits
  a_rd_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && (paddr[2] == swmf_pkg::REG_WINDOW_LENGTH) |->
      prdata[swmf_pkg::APB_DATA_W-1:swmf_pkg::WLEN_W] == '0)
    else $error("window length read has stray bits");

  // a written window length reads back
  a_wr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == swmf_pkg::REG_WINDOW_LENGTH) |=>
      ((psel && !pwrite && (paddr[2] == swmf_pkg::REG_WINDOW_LENGTH)) ?
        (prdata[swmf_pkg::WLEN_W-1:0] == $past(pwdata[swmf_pkg::WLEN_W-1:0])) : 1'b1))
    else $error("window length readback mismatch");

endmodule

bind sliding_window_median_filter swmf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_swmf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);
